>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. They expect the signals
// clk and rst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/sexpr_tok_pkg.sv
// ----------------------------------------------------------------------------
// sexpr_tok_pkg
// Types and constants of the S-expression stream tokenizer.
// ----------------------------------------------------------------------------
package sexpr_tok_pkg;

    // Default configuration of the tokenizer.
    localparam int DEF_MAX_DEPTH  = 100;
    localparam int DEF_NODE_BYTES = 24;

    // Fixed field widths.
    localparam int DEPTH_W  = 7;
    localparam int BUDGET_W = 32;

    // Number of entries in the result queue (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHR_OPEN   = 8'h28;
    localparam logic [7:0] CHR_CLOSE  = 8'h29;
    localparam logic [7:0] CHR_ESCAPE = 8'h5C;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_NUL    = 8'h00;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_ATOM = 2'd1,
        MODE_ESC  = 2'd2
    } lex_mode_t;

    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_BYTE  = 3'd2,
        KIND_END   = 3'd3,
        KIND_DONE  = 3'd4,
        KIND_ERROR = 3'd5
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BUDGET    = 2'd1,
        ERR_DEPTH     = 2'd2,
        ERR_UNMATCHED = 2'd3
    } error_code_t;

    typedef struct packed {
        token_kind_t         kind;
        logic [7:0]          tbyte;
        logic [DEPTH_W-1:0]  depth;
        error_code_t         code;
        logic                last;
    } token_t;

endpackage

>>> rtl/sexpr_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// sexpr_stream_tokenizer
// Byte-stream S-expression tokenizer with nesting depth, escapes and a
// per-expression memory budget.
// ----------------------------------------------------------------------------
// The tokenizer takes one text byte (or a restart) per cycle while s_tready
// is high and turns it into zero, one or two tokens in the same clock edge:
// the whole decision for a byte is a single pass of shallow logic from the
// input port and the lexer state into a four-entry result queue, from which
// a token reaches the output once the tokens ahead of it have been taken.
// A parenthesis that ends an atom yields an atom end plus its own token; any
// other byte yields at most one. The input runs at one byte per cycle for as
// long as each byte yields at most one token and the output is taken, and is
// otherwise paced by the output, which carries one token per cycle while m_tready is high.
// s_tready drops when the result queue has fewer than two free entries.
// After an error the block drops all text until a restart transfer;
// byte_budget is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sexpr_stream_tokenizer
    import sexpr_tok_pkg::*;
#(
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int NODE_BYTES = DEF_NODE_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,

    // Configuration: byte_budget, zero means unlimited.
    input  logic                cfg_we,
    input  logic [BUDGET_W-1:0] cfg_wdata,

    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] text_byte
    input  logic [0:0]          s_tuser,   // [0] func (1 = restart)

    // Token stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [7:0] token_byte, [14:8] nest_depth,
                                           // [16:15] error_code, [23:17] zero
    output logic [2:0]          m_tuser,   // [2:0] token_kind
    output logic                m_tlast    // last_of_run
);

    localparam int SUM_W  = BUDGET_W + 2;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = PTR_W + 1;

    localparam logic [SUM_W-1:0]   NODE_1  = SUM_W'(NODE_BYTES);
    localparam logic [SUM_W-1:0]   NODE_E1 = SUM_W'(NODE_BYTES + 1);
    localparam logic [SUM_W-1:0]   NODE_E2 = SUM_W'(NODE_BYTES + 2);
    localparam logic [SUM_W-1:0]   NODE_2E = SUM_W'(2 * NODE_BYTES + 1);
    localparam logic [DEPTH_W:0]   DEPTH_LIMIT = (DEPTH_W + 1)'(MAX_DEPTH);
    localparam logic [CNT_W-1:0]   ROOM_LIMIT  = CNT_W'(QUEUE_DEPTH - 2);
    localparam logic [CNT_W-1:0]   QUEUE_FULL  = CNT_W'(QUEUE_DEPTH);

    // Saturate a grown sum back into a 32-bit counter.
    function automatic logic [BUDGET_W-1:0] sat32(input logic [SUM_W-1:0] s);
        logic [BUDGET_W-1:0] r;
        r = (|s[SUM_W-1:BUDGET_W]) ? '1 : s[BUDGET_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    logic [BUDGET_W-1:0] budget_reg;
    lex_mode_t           mode_reg,    mode_next;
    logic [DEPTH_W-1:0]  depth_reg,   depth_next;
    logic [BUDGET_W-1:0] charged_reg, charged_next;
    logic [BUDGET_W-1:0] alen_reg,    alen_next;
    logic                error_reg,   error_next;

    // ------------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------------
    logic       accept;
    logic       restart;
    logic [7:0] chr;
    logic       is_open, is_close, is_space, is_escape, delim;
    logic       active;

    assign accept    = s_tvalid && s_tready;
    assign restart   = s_tuser[0];
    assign chr       = s_tdata;
    assign is_open   = (chr == CHR_OPEN);
    assign is_close  = (chr == CHR_CLOSE);
    assign is_space  = (chr == CHR_SPACE) || ((chr >= CHR_TAB) && (chr <= CHR_CR));
    assign is_escape = (chr == CHR_ESCAPE);
    assign delim     = is_open || is_close || is_space;

    // A text byte that actually does something.
    assign active = accept && !restart && !error_reg && (chr != CHR_NUL);

    // ------------------------------------------------------------------------
    // Budget checks. Every check is one add of at most three inputs and one compare.
    // When the atom end passes its check under a nonzero budget, the charge
    // cannot saturate, so the check for the following open can be formed
    // directly from the old charge in parallel.
    // ------------------------------------------------------------------------
    logic [SUM_W-1:0] sum_byte, sum_end, sum_open_atom, sum_open_bare;
    logic             unlimited;
    logic             fit_byte, fit_end, fit_open_atom, fit_open_bare;

    assign sum_byte      = {2'b00, charged_reg} + {2'b00, alen_reg} + NODE_E2;
    assign sum_end       = {2'b00, charged_reg} + {2'b00, alen_reg} + NODE_E1;
    assign sum_open_atom = {2'b00, charged_reg} + {2'b00, alen_reg} + NODE_2E;
    assign sum_open_bare = {2'b00, charged_reg} + NODE_1;

    assign unlimited     = (budget_reg == '0);
    assign fit_byte      = unlimited || (sum_byte      <= {2'b00, budget_reg});
    assign fit_end       = unlimited || (sum_end       <= {2'b00, budget_reg});
    assign fit_open_atom = unlimited || (sum_open_atom <= {2'b00, budget_reg});
    assign fit_open_bare = unlimited || (sum_open_bare <= {2'b00, budget_reg});

    // Path selection for the current byte.
    logic             add_path;    // byte goes into the atom
    logic             esc_path;    // backslash inside or starting an atom
    logic             end_try;     // delimiter that closes an open atom
    logic             ended;       // the atom end succeeded
    logic             do_delim;    // the delimiter itself is handled
    logic             fit_open;
    logic             too_deep;
    logic [DEPTH_W:0] depth_up;
    logic [DEPTH_W-1:0] depth_dn;

    assign add_path = active && ((mode_reg == MODE_ESC) || (!delim && !is_escape));
    assign esc_path = active && (mode_reg != MODE_ESC) && !delim && is_escape;
    assign end_try  = active && (mode_reg == MODE_ATOM) && delim;
    assign ended    = end_try && fit_end;
    assign do_delim = active && (mode_reg != MODE_ESC) && delim
                      && ((mode_reg == MODE_NONE) || fit_end);
    assign fit_open = ended ? fit_open_atom : fit_open_bare;
    assign depth_up = {1'b0, depth_reg} + 1'b1;
    assign too_deep = (depth_up >= DEPTH_LIMIT);
    assign depth_dn = depth_reg - 1'b1;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        mode_next    = mode_reg;
        depth_next   = depth_reg;
        charged_next = charged_reg;
        alen_next    = alen_reg;
        error_next   = error_reg;

        if (accept && restart)
        begin
            mode_next    = MODE_NONE;
            depth_next   = '0;
            charged_next = '0;
            alen_next    = '0;
            error_next   = 1'b0;
        end
        else
        begin
            if (add_path)
            begin
                mode_next = MODE_ATOM;
                if (fit_byte)
                begin
                    if (alen_reg != '1)
                    begin
                        alen_next = alen_reg + 1'b1;
                    end
                end
                else
                begin
                    error_next = 1'b1;
                end
            end

            if (esc_path)
            begin
                mode_next = MODE_ESC;
            end

            if (end_try && !fit_end)
            begin
                error_next = 1'b1;
            end

            if (ended)
            begin
                charged_next = sat32(sum_end);
                alen_next    = '0;
                mode_next    = MODE_NONE;
            end

            if (do_delim)
            begin
                if (is_open)
                begin
                    if (!fit_open)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        charged_next = ended ? sat32(sum_open_atom) : sat32(sum_open_bare);
                        if (too_deep)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            depth_next = depth_up[DEPTH_W-1:0];
                        end
                    end
                end
                else if (is_close)
                begin
                    if (depth_reg == '0)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_dn;
                        if (depth_dn == '0)
                        begin
                            charged_next = '0;
                            alen_next    = '0;
                            mode_next    = MODE_NONE;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tokens produced by the current byte
    // ------------------------------------------------------------------------
    token_t         tok_a, tok_b, dtok;
    logic           dtok_valid;
    logic [1:0]     tok_count;

    // Token of the delimiter itself.
    always_comb
    begin
        dtok       = '{kind: KIND_OPEN, tbyte: '0, depth: depth_reg,
                       code: ERR_NONE, last: 1'b0};
        dtok_valid = 1'b0;
        if (is_open)
        begin
            dtok_valid = 1'b1;
            if (!fit_open)
            begin
                dtok.kind = KIND_ERROR;
                dtok.code = ERR_BUDGET;
            end
            else if (too_deep)
            begin
                dtok.kind = KIND_ERROR;
                dtok.code = ERR_DEPTH;
            end
            else
            begin
                dtok.depth = depth_up[DEPTH_W-1:0];
            end
        end
        else if (is_close)
        begin
            dtok_valid = 1'b1;
            if (depth_reg == '0)
            begin
                dtok.kind = KIND_ERROR;
                dtok.code = ERR_UNMATCHED;
            end
            else
            begin
                dtok.depth = depth_dn;
                dtok.kind  = (depth_dn == '0) ? KIND_DONE : KIND_CLOSE;
            end
        end
    end

    always_comb
    begin
        tok_a     = '{kind: KIND_BYTE, tbyte: '0, depth: depth_reg,
                      code: ERR_NONE, last: 1'b1};
        tok_b     = dtok;
        tok_count = 2'd0;

        if (add_path)
        begin
            tok_count = 2'd1;
            if (fit_byte)
            begin
                tok_a.tbyte = chr;
            end
            else
            begin
                tok_a.kind = KIND_ERROR;
                tok_a.code = ERR_BUDGET;
            end
        end
        else if (end_try)
        begin
            tok_count = 2'd1;
            if (!fit_end)
            begin
                tok_a.kind = KIND_ERROR;
                tok_a.code = ERR_BUDGET;
            end
            else
            begin
                tok_a.kind = KIND_END;
                if (dtok_valid)
                begin
                    tok_a.last = 1'b0;
                    tok_count  = 2'd2;
                end
            end
        end
        else if (do_delim && dtok_valid)
        begin
            // The delimiter token is the only one of this byte.
            tok_a      = dtok;
            tok_a.last = 1'b1;
            tok_count  = 2'd1;
        end
        tok_b.last = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Result queue: up to two writes and one read per cycle.
    // ------------------------------------------------------------------------
    token_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_b;

    assign pop         = m_tvalid && m_tready;
    assign wr_ptr_b    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(tok_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(tok_count) - CNT_W'(pop);
    assign s_tready    = (count_reg <= ROOM_LIMIT);

    always_ff @(posedge clk)
    begin
        if (tok_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= tok_a;
        end
        if (tok_count == 2'd2)
        begin
            queue_reg[wr_ptr_b] <= tok_b;
        end
    end

    token_t head;
    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = head.kind;
    assign m_tdata  = {7'd0, head.code, head.depth, head.tbyte};
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg  <= '0;
            mode_reg    <= MODE_NONE;
            depth_reg   <= '0;
            charged_reg <= '0;
            alen_reg    <= '0;
            error_reg   <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
            mode_reg    <= mode_next;
            depth_reg   <= depth_next;
            charged_reg <= charged_next;
            alen_reg    <= alen_next;
            error_reg   <= error_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_ALWAYS(a_queue_bound, count_reg <= QUEUE_FULL, "result queue overfilled")
    `ASSERT_CLK(a_error_silent, error_reg |-> (tok_count == 2'd0),
                "token after error latched")
    `ASSERT_CLK(a_restart_clears, (accept && restart) |=>
                (!error_reg && depth_reg == '0 && mode_reg == MODE_NONE),
                "restart did not clear state")
    `ASSERT_CLK(a_depth_bound,
                depth_reg < DEPTH_LIMIT[DEPTH_W-1:0] || DEPTH_LIMIT[DEPTH_W],
                "nesting depth over limit")

endmodule
